FILE: rtl/tpp_pkg.sv
`default_nettype none

package tpp_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned AXIS_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = COORD_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 1'b1;

  // axis codes, the unused codes 2 and 3 fall back to z
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD,
    S_CMPF,
    S_CMPB,
    S_SWAP,
    S_ERD,
    S_ELD,
    S_EWAIT
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [TAG_W-1:0]          tag;
  } point_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    point_t           wdata;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/tpp_in_if.sv
`default_nettype none

interface tpp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [15:0]        point_tag;
  logic               last_in;

  modport source (output valid, coord_x, coord_y, coord_z, point_tag, last_in,
                  input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, point_tag, last_in,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/tpp_out_if.sv
`default_nettype none

interface tpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [15:0]        out_tag;
  logic               left_side;
  logic [6:0]         border_count;
  logic               overflow;
  logic               last_out;

  modport source (output valid, out_x, out_y, out_z, out_tag, left_side,
                  border_count, overflow, last_out, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_tag, left_side,
                  border_count, overflow, last_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/threshold_two_pointer_partition.sv
// load: one beat per cycle, the beat carrying last_in starts the partition
// partition: a front advance passes S_RD and S_CMPF, a back step adds S_CMPB, a back step
//   with swap adds S_SWAP as well; these steps are set by the shared comparator and the
//   single write port of the point store
// emission: S_ERD, S_ELD and S_EWAIT per point, n points, no input beat accepted until the last is taken
// reset: async active low, clears sequencer, fill count, overflow flag and both registers
`default_nettype none

module threshold_two_pointer_partition (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tpp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [tpp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  tpp_in_if.sink                                 in_i,
  tpp_out_if.source                              out_o
);
  import tpp_pkg::*;

  // sequencer
  state_e state_q, state_d;

  // configuration registers
  logic signed [COORD_W-1:0] pivot_q;
  logic [AXIS_W-1:0]         axis_q;

  // buffer bookkeeping
  logic [CNT_W-1:0] fill_q;
  logic             ovf_q;
  logic [CNT_W-1:0] n_q;      // points held in the closed set

  // two-pointer walk; back is kept as back + 1 so it never goes negative
  logic [CNT_W-1:0] front_q;
  logic [CNT_W-1:0] bp1_q;
  logic [CNT_W-1:0] back_idx;
  logic [CNT_W-1:0] k_q;      // emission position

  point_t   hold_q;           // front entry parked for the second half of a swap
  point_t   rd_a, rd_b;
  mem_req_t mem_req;

  // output register
  logic   out_valid_q;
  point_t out_pt_q;
  logic   out_left_q;
  logic   out_last_q;

  // shared signed comparator
  logic signed [COORD_W-1:0] cmp_a, cmp_b;
  logic                      cmp_lt;

  logic in_beat, out_beat, buf_full;
  logic front_more, back_more;

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_beat = out_o.valid && out_o.ready;
  assign buf_full = (fill_q == CNT_W'(MAX_ITEMS));
  assign back_idx = bp1_q - 1'b1;

  // loop test after the step: front <= back
  assign front_more = (front_q + 1'b1) < bp1_q;   // after front advances
  assign back_more  = front_q < back_idx;         // after back retreats

  function automatic logic signed [COORD_W-1:0] axis_coord(point_t p,
                                                          logic [AXIS_W-1:0] a);
    logic signed [COORD_W-1:0] c;
    case (a)
      AXIS_X:  c = p.x;
      AXIS_Y:  c = p.y;
      default: c = p.z;
    endcase
    return c;
  endfunction

  assign cmp_lt = cmp_a < cmp_b;

  tpp_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:  if (in_beat && in_i.last_in) state_d = S_RD;
      S_RD:    state_d = S_CMPF;
      S_CMPF: begin
        if (cmp_lt) state_d = front_more ? S_RD : S_ERD;
        else        state_d = S_CMPB;
      end
      S_CMPB: begin
        if (!cmp_lt) state_d = S_SWAP;
        else         state_d = back_more ? S_RD : S_ERD;
      end
      S_SWAP:  state_d = back_more ? S_RD : S_ERD;
      S_ERD:   state_d = S_ELD;
      S_ELD:   state_d = S_EWAIT;
      S_EWAIT: begin
        if (out_beat) state_d = out_last_q ? S_LOAD : S_ERD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // outputs of the sequencer: store access, comparator operands, input ready
  always_comb begin
    mem_req         = '0;
    mem_req.raddr_a = front_q[IDX_W-1:0];
    mem_req.raddr_b = back_idx[IDX_W-1:0];
    cmp_a           = axis_coord(rd_a, axis_q);
    cmp_b           = pivot_q;
    in_i.ready      = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_i.ready         = 1'b1;
        mem_req.we         = in_beat && !buf_full;
        mem_req.waddr      = fill_q[IDX_W-1:0];
        mem_req.wdata.x    = in_i.coord_x;
        mem_req.wdata.y    = in_i.coord_y;
        mem_req.wdata.z    = in_i.coord_z;
        mem_req.wdata.tag  = in_i.point_tag;
      end
      S_CMPB: begin
        // back <= pivot is the same as not (pivot < back)
        cmp_a         = pivot_q;
        cmp_b         = axis_coord(rd_b, axis_q);
        mem_req.we    = !cmp_lt;
        mem_req.waddr = front_q[IDX_W-1:0];
        mem_req.wdata = rd_b;
      end
      S_SWAP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = back_idx[IDX_W-1:0];
        mem_req.wdata = hold_q;
      end
      S_ERD, S_ELD, S_EWAIT: begin
        mem_req.raddr_a = k_q[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      pivot_q     <= '0;
      axis_q      <= '0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      front_q     <= '0;
      bp1_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PIVOT: pivot_q <= cfg_data_i;
          REG_AXIS:  axis_q  <= cfg_data_i[AXIS_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        S_LOAD: begin
          if (in_beat) begin
            if (!buf_full) fill_q <= fill_q + 1'b1;
            else           ovf_q  <= 1'b1;
            if (in_i.last_in) begin
              // set size includes this beat unless it was dropped
              front_q <= '0;
              k_q     <= '0;
              bp1_q   <= buf_full ? fill_q : fill_q + 1'b1;
              n_q     <= buf_full ? fill_q : fill_q + 1'b1;
            end
          end
        end
        S_CMPF: if (cmp_lt) front_q <= front_q + 1'b1;
        S_CMPB: if (cmp_lt) bp1_q <= bp1_q - 1'b1;
        S_SWAP: bp1_q <= bp1_q - 1'b1;
        S_ELD:  out_valid_q <= 1'b1;
        S_EWAIT: begin
          if (out_beat) begin
            out_valid_q <= 1'b0;
            k_q         <= k_q + 1'b1;
            if (out_last_q) begin
              fill_q <= '0;
              ovf_q  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_CMPB) hold_q <= rd_a;
    if (state_q == S_ELD) begin
      out_pt_q   <= rd_a;
      out_left_q <= k_q < front_q;
      out_last_q <= k_q == (n_q - 1'b1);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_x        = out_pt_q.x;
  assign out_o.out_y        = out_pt_q.y;
  assign out_o.out_z        = out_pt_q.z;
  assign out_o.out_tag      = out_pt_q.tag;
  assign out_o.left_side    = out_left_q;
  assign out_o.border_count = front_q;
  assign out_o.overflow     = ovf_q;
  assign out_o.last_out     = out_last_q;

`ifndef ASSERT_OFF
  // loading and emission never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is shown");

  // second half of a swap only follows a taken back compare
  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP) |-> ($past(state_q) == S_CMPB))
    else $error("swap write without back compare");

  // a walk step is only issued while front <= back
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (front_q < bp1_q))
    else $error("partition step past the crossing");

  // emitted position stays inside the closed set
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (k_q < n_q))
    else $error("emission beyond the buffered points");
`endif

endmodule

`default_nettype wire

FILE: rtl/tpp_store.sv
`default_nettype none

module tpp_store (
  input  wire logic              clk_i,
  input  wire tpp_pkg::mem_req_t req_i,
  output tpp_pkg::point_t        rdata_a_o,
  output tpp_pkg::point_t        rdata_b_o
);
  import tpp_pkg::*;

  point_t mem [MAX_ITEMS];

  // one write port, two registered read ports (read-before-write)
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_o <= mem[req_i.raddr_a];
    rdata_b_o <= mem[req_i.raddr_b];
  end

endmodule

`default_nettype wire
